/* sv/jac_pkg.sv */
// shared types, constants and root table for the joystick axis conditioner
package jac_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
   localparam int WQ        = 30;

   typedef enum logic [2:0] {
      REG_ADC_FULL_SCALE  = 3'd0,
      REG_SCREEN_WIDTH    = 3'd1,
      REG_SCREEN_HEIGHT   = 3'd2,
      REG_CURVE_EXPONENT  = 3'd3,
      REG_SMOOTH_WEIGHT   = 3'd4,
      REG_DEAD_ZONE_WIDTH = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SHAPE,
      ST_SQ_M,
      ST_SQ_W,
      ST_NE_M,
      ST_NE_W,
      ST_EX_M,
      ST_EX_W,
      ST_MAG,
      ST_SCL_M,
      ST_SCL_W,
      ST_SM1_M,
      ST_SM2_M,
      ST_SM_W,
      ST_FIN
   } state_type;

   typedef logic [31:0] root_tab_type [16];

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res  = '0;
      bitv = 64'd1 << 62;
      rem  = v;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q30 for k = 1..16, each the floor root of the one before
   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0] r;
      r = 64'd1 << (WQ + 1);
      for (int k = 0; k < 16; k++) begin
         r = isqrt64(r << WQ);
         tab[k] = r[31:0];
      end
      return tab;
   endfunction

   localparam root_tab_type ROOT_TAB = root_table();

endpackage

/* sv/joystick_axis_conditioner.sv */
// joystick axis conditioner: normalize, centre, dead zone, power curve, scale, smooth
// a recalibrate word is taken in idle and gives no result; a zero full scale goes
// straight to the finish state; a sample runs each axis through divider, shaping,
// power curve, scaling and smoothing, skipping the divider, curve or smoothing on
// the fast paths, before the finish state offers its result.
// one word at a time; the work is set by the shared 32x32 multiplier,
// which runs 16 squarings and 16 root products per axis, plus a 12-step divider.
// reset (synchronous): registers to defaults, calibration and history cleared.
module joystick_axis_conditioner
   import jac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_x[11:0], raw_y[23:12]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pos_x[19:0], pos_y[39:20]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   // configuration
   logic [11:0] afs_ff, span_w_ff, span_h_ff;
   logic [10:0] exp_ff;
   logic [7:0]  wgt_ff;
   logic [13:0] dz_ff;

   // persistent state
   logic               cal_ff, cal_in;
   logic signed [13:0] offx_ff, offx_in, offy_ff, offy_in;
   logic               hp_ff, hp_in;
   logic [19:0]        prevx_ff, prevx_in, prevy_ff, prevy_in;

   // sequencer
   state_type   state_ff, state_in;
   logic        axis_ff, axis_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        calnow_ff, calnow_in;
   logic        zero_ff, zero_in;
   logic [11:0] rawx_ff, rawx_in, rawy_ff, rawy_in;
   logic [12:0] rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic [12:0] norm_ff, norm_in;
   logic [12:0] m_ff, m_in;
   logic        dpos_ff, dpos_in;
   logic [3:0]  p_ff, p_in;
   logic [31:0] x_ff, x_in;
   logic [15:0] frac_ff, frac_in;
   logic [15:0] g_ff, g_in;
   logic [5:0]  ip_ff, ip_in;
   logic [31:0] y_ff, y_in;
   logic [12:0] mag_ff, mag_in;
   logic [19:0] t_ff, t_in;
   logic [28:0] acc_ff, acc_in;
   logic [19:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [63:0] prod_ff;
   logic [31:0] mul_a, mul_b;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [11:0]        raw_cur, span_cur;
   logic signed [13:0] off_cur;
   logic [12:0]        rem_src, rem2;
   logic               ge;
   logic signed [14:0] adj, d;
   logic [12:0]        twod;
   logic               dz_hit;
   logic [10:0]        e_cl;
   logic [7:0]         w_cl;
   logic [3:0]         p_v;
   logic [31:0]        xs;
   logic [19:0]        n_v;
   logic [21:0]        ne;
   logic [43:0]        val;
   logic [13:0]        c2;
   logic [28:0]        sum;
   logic [19:0]        prev_cur;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         afs_ff    <= 12'd4095;
         span_w_ff <= 12'd800;
         span_h_ff <= 12'd600;
         exp_ff    <= 11'd256;
         wgt_ff    <= 8'd0;
         dz_ff     <= 14'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ADC_FULL_SCALE:  afs_ff    <= csr_wdata[11:0];
            REG_SCREEN_WIDTH:    span_w_ff <= csr_wdata[11:0];
            REG_SCREEN_HEIGHT:   span_h_ff <= csr_wdata[11:0];
            REG_CURVE_EXPONENT:  exp_ff    <= csr_wdata[10:0];
            REG_SMOOTH_WEIGHT:   wgt_ff    <= csr_wdata[7:0];
            REG_DEAD_ZONE_WIDTH: dz_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_ff       <= 1'b0;
         offx_ff      <= '0;
         offy_ff      <= '0;
         hp_ff        <= 1'b0;
         prevx_ff     <= '0;
         prevy_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         hp_ff        <= hp_in;
         prevx_ff     <= prevx_in;
         prevy_ff     <= prevy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      cnt_ff      <= cnt_in;
      calnow_ff   <= calnow_in;
      zero_ff     <= zero_in;
      rawx_ff     <= rawx_in;
      rawy_ff     <= rawy_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      norm_ff     <= norm_in;
      m_ff        <= m_in;
      dpos_ff     <= dpos_in;
      p_ff        <= p_in;
      x_ff        <= x_in;
      frac_ff     <= frac_in;
      g_ff        <= g_in;
      ip_ff       <= ip_in;
      y_ff        <= y_in;
      mag_ff      <= mag_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      posx_ff     <= posx_in;
      posy_ff     <= posy_in;
      rsp_data_ff <= rsp_data_in;
      // shared multiplier, product registered
      prod_ff     <= 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      cal_in       = cal_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      hp_in        = hp_ff;
      prevx_in     = prevx_ff;
      prevy_in     = prevy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      calnow_in    = calnow_ff;
      zero_in      = zero_ff;
      rawx_in      = rawx_ff;
      rawy_in      = rawy_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      norm_in      = norm_ff;
      m_in         = m_ff;
      dpos_in      = dpos_ff;
      p_in         = p_ff;
      x_in         = x_ff;
      frac_in      = frac_ff;
      g_in         = g_ff;
      ip_in        = ip_ff;
      y_in         = y_ff;
      mag_in       = mag_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      mul_a        = '0;
      mul_b        = '0;

      raw_cur  = axis_ff ? rawy_ff : rawx_ff;
      span_cur = axis_ff ? span_h_ff : span_w_ff;
      off_cur  = axis_ff ? offy_ff : offx_ff;
      prev_cur = axis_ff ? prevy_ff : prevx_ff;
      e_cl     = (exp_ff < 11'd256) ? 11'd256 : ((exp_ff > 11'd1024) ? 11'd1024 : exp_ff);
      w_cl     = (wgt_ff > 8'd243) ? 8'd243 : wgt_ff;

      rem_src = (cnt_ff == 4'd0) ? {1'b0, raw_cur} : rem_ff;
      rem2    = {rem_src[11:0], 1'b0};
      ge      = (rem2 >= {1'b0, afs_ff});

      if (calnow_ff) begin
         off_cur = 14'(HALF_Q) - $signed({1'b0, norm_ff});
      end
      adj = 15'(off_cur) + $signed({2'b0, norm_ff});
      if (adj < 0) begin
         adj = '0;
      end else if (adj > 15'(ONE_Q)) begin
         adj = 15'(ONE_Q);
      end
      d      = adj - 15'(HALF_Q);
      twod   = d[14] ? 13'(-(d <<< 1)) : 13'(d <<< 1);
      dz_hit = ({1'b0, twod} < dz_ff);

      // leading one of the magnitude about to be taken
      p_v = '0;
      for (int i = 0; i < 12; i++) begin
         if (!dz_hit && twod[i]) begin
            p_v = 4'(i);
         end
      end

      xs  = prod_ff[61:30];
      n_v = (20'(4'd12 - p_ff) << 16) - 20'(frac_ff);
      ne  = prod_ff[29:8];
      val = {y_ff, 12'b0} >> (7'd30 + 7'(ip_ff));
      c2  = dpos_ff ? 14'(ONE_Q) + 14'(mag_ff) : 14'(ONE_Q) - 14'(mag_ff);
      sum = acc_ff + prod_ff[28:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  cal_in   = 1'b0;
                  hp_in    = 1'b0;
                  offx_in  = '0;
                  offy_in  = '0;
                  prevx_in = '0;
                  prevy_in = '0;
               end else if (afs_ff == 12'd0) begin
                  zero_in  = 1'b1;
                  posx_in  = '0;
                  posy_in  = '0;
                  state_in = ST_FIN;
               end else begin
                  zero_in   = 1'b0;
                  calnow_in = !cal_ff;
                  cal_in    = 1'b1;
                  rawx_in   = req_tdata[11:0];
                  rawy_in   = req_tdata[23:12];
                  axis_in   = 1'b0;
                  cnt_in    = '0;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == 4'd0 && raw_cur >= afs_ff) begin
               norm_in  = 13'(ONE_Q);
               state_in = ST_SHAPE;
            end else begin
               rem_in = ge ? rem2 - {1'b0, afs_ff} : rem2;
               quo_in = {quo_ff[10:0], ge};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd11) begin
                  norm_in  = {1'b0, quo_ff[10:0], ge};
                  state_in = ST_SHAPE;
               end
            end
         end
         ST_SHAPE: begin
            if (calnow_ff) begin
               if (axis_ff) offy_in = off_cur;
               else         offx_in = off_cur;
            end
            m_in    = dz_hit ? 13'd0 : twod;
            dpos_in = dz_hit | !d[14];
            p_in    = p_v;
            x_in    = 32'(m_in[11:0]) << (5'd30 - 5'(p_v));
            frac_in = '0;
            cnt_in  = '0;
            if (m_in == 13'd0) begin
               mag_in   = '0;
               state_in = ST_SCL_M;
            end else if (m_in[12]) begin
               mag_in   = 13'(ONE_Q);
               state_in = ST_SCL_M;
            end else if (e_cl == 11'd256) begin
               mag_in   = m_in;
               state_in = ST_SCL_M;
            end else begin
               state_in = ST_SQ_M;
            end
         end
         ST_SQ_M: begin
            mul_a    = x_ff;
            mul_b    = x_ff;
            state_in = ST_SQ_W;
         end
         ST_SQ_W: begin
            // log2 fraction bit by repeated squaring
            if (xs[31]) begin
               frac_in = frac_ff | (16'h8000 >> cnt_ff);
               x_in    = xs >> 1;
            end else begin
               x_in = xs;
            end
            cnt_in   = cnt_ff + 4'd1;
            state_in = (cnt_ff == 4'd15) ? ST_NE_M : ST_SQ_M;
         end
         ST_NE_M: begin
            mul_a    = 32'(n_v);
            mul_b    = 32'(e_cl);
            state_in = ST_NE_W;
         end
         ST_NE_W: begin
            if (ne[15:0] != 16'd0) begin
               ip_in = ne[21:16] + 6'd1;
               g_in  = 16'd0 - ne[15:0];
            end else begin
               ip_in = ne[21:16];
               g_in  = '0;
            end
            y_in     = 32'd1 << WQ;
            cnt_in   = '0;
            state_in = ST_EX_M;
         end
         ST_EX_M: begin
            mul_a    = y_ff;
            mul_b    = g_ff[4'd15 - cnt_ff] ? ROOT_TAB[cnt_ff] : (32'd1 << WQ);
            state_in = ST_EX_W;
         end
         ST_EX_W: begin
            y_in     = prod_ff[61:30];
            cnt_in   = cnt_ff + 4'd1;
            state_in = (cnt_ff == 4'd15) ? ST_MAG : ST_EX_M;
         end
         ST_MAG: begin
            mag_in   = (val > 44'(ONE_Q)) ? 13'(ONE_Q) : val[12:0];
            state_in = ST_SCL_M;
         end
         ST_SCL_M: begin
            mul_a    = 32'(c2);
            mul_b    = 32'(span_cur);
            state_in = ST_SCL_W;
         end
         ST_SCL_W: begin
            t_in = prod_ff[24:5];
            if (hp_ff && !calnow_ff) begin
               state_in = ST_SM1_M;
            end else begin
               if (axis_ff) posy_in = prod_ff[24:5];
               else         posx_in = prod_ff[24:5];
               axis_in  = 1'b1;
               cnt_in   = '0;
               state_in = axis_ff ? ST_FIN : ST_DIV;
            end
         end
         ST_SM1_M: begin
            mul_a    = 32'(9'd256 - 9'(w_cl));
            mul_b    = 32'(prev_cur);
            state_in = ST_SM2_M;
         end
         ST_SM2_M: begin
            acc_in   = prod_ff[28:0];
            mul_a    = 32'(w_cl);
            mul_b    = 32'(t_ff);
            state_in = ST_SM_W;
         end
         ST_SM_W: begin
            if (axis_ff) posy_in = sum[27:8];
            else         posx_in = sum[27:8];
            axis_in  = 1'b1;
            cnt_in   = '0;
            state_in = axis_ff ? ST_FIN : ST_DIV;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {posy_ff, posx_ff};
               if (!zero_ff) begin
                  prevx_in = posx_ff;
                  prevy_in = posy_ff;
                  hp_in    = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_valid_ff && rsp_tready && state_ff != ST_FIN) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

/* sv/jac_checker.sv */
// port-level checks for the joystick axis conditioner
module jac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_we,
   input logic [2:0]  csr_index,
   input logic [13:0] csr_wdata
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word right after reset");

   // the input side is closed in the cycle after a sample word is taken
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("input ready right after a sample word");

   // positions never exceed the largest scaled span
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:0] <= 20'd1048320) && (rsp_tdata[39:20] <= 20'd1048320))
      else $error("position out of range");

endmodule

bind joystick_axis_conditioner jac_checker u_jac_checker (.*);

/* tb/tb_top.sv */
// testbench for the joystick axis conditioner: own predictor, random stimulus and checks
module tb_top;
   import jac_pkg::*;

   localparam int LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   joystick_axis_conditioner u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and state
   logic [11:0] full_scale, span_x, span_y;
   logic [10:0] curve_exp;
   logic [7:0]  smooth_w;
   logic [13:0] dz_width;
   logic        calibrated, has_prev;
   int          offs_x, offs_y;
   logic [19:0] prev_x, prev_y;

   logic [39:0] pos_queue[$];
   int          errors = 0;
   int          cycles = 0;
   int          hold_cycles = 0;
   bit          rx_idle_ok = 1'b1;
   bit          tx_idle_ok = 1'b1;

   logic [31:0] roots[16];

   task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic int unsigned curve_pow(int unsigned m, int unsigned e);
      int unsigned p, frac, f, g;
      logic [63:0] x, n, ne, ip, y, val;
      p = 0;
      frac = 0;
      g = 0;
      if (m == 0) return 0;
      if (m >= ONE_Q) return ONE_Q;
      if (e == 256) return m;
      while ((m >> (p + 1)) != 0) p++;
      x = 64'(m) << (WQ - p);
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> WQ;
         if (x >= (64'd1 << (WQ + 1))) begin
            frac |= 1 << (15 - i);
            x >>= 1;
         end
      end
      n = (64'(FRAC_BITS - p) << 16) - frac;
      ne = (n * e) >> 8;
      ip = ne >> 16;
      f = ne[15:0];
      if (f != 0) begin
         ip++;
         g = 65536 - f;
      end
      y = 64'd1 << WQ;
      for (int k = 1; k <= 16; k++)
         if ((g >> (16 - k)) & 1) y = (y * roots[k-1]) >> WQ;
      if (ip > 32) return 0;
      val = (y << FRAC_BITS) >> (WQ + ip);
      return val > ONE_Q ? ONE_Q : int'(val);
   endfunction

   function automatic int unsigned norm_axis(logic [11:0] raw);
      logic [63:0] q;
      q = (64'(raw) << FRAC_BITS) / full_scale;
      return q > ONE_Q ? ONE_Q : int'(q);
   endfunction

   function automatic logic [19:0] axis_pixels(logic [11:0] raw, int offs, logic [11:0] span);
      int adj, d, e;
      int unsigned m, mag, c2;
      logic [63:0] t;
      adj = int'(norm_axis(raw)) + offs;
      if (adj < 0) adj = 0;
      if (adj > ONE_Q) adj = ONE_Q;
      d = adj - HALF_Q;
      if (2 * (d < 0 ? -d : d) < int'(dz_width)) d = 0;
      m = 2 * (d < 0 ? -d : d);
      if (m > ONE_Q) m = ONE_Q;
      e = curve_exp < 256 ? 256 : (curve_exp > 1024 ? 1024 : int'(curve_exp));
      mag = curve_pow(m, e);
      c2 = d >= 0 ? ONE_Q + mag : ONE_Q - mag;
      t = (64'(c2) * span * 256) >> (FRAC_BITS + 1);
      return t[19:0];
   endfunction

   function automatic logic [19:0] blend(logic [19:0] p, logic [19:0] t);
      logic [63:0] w, s;
      w = smooth_w > 243 ? 243 : smooth_w;
      s = ((256 - w) * p + w * t) >> 8;
      return s[19:0];
   endfunction

   function automatic void predict_position(logic kind, logic [11:0] rx, logic [11:0] ry);
      logic [19:0] tx, ty;
      if (kind) begin
         calibrated = 0;
         has_prev = 0;
         offs_x = 0;
         offs_y = 0;
         prev_x = 0;
         prev_y = 0;
         return;
      end
      if (full_scale == 0) begin
         pos_queue.push_back('0);
         return;
      end
      if (!calibrated) begin
         offs_x = HALF_Q - int'(norm_axis(rx));
         offs_y = HALF_Q - int'(norm_axis(ry));
         calibrated = 1;
         has_prev = 0;
      end
      tx = axis_pixels(rx, offs_x, span_x);
      ty = axis_pixels(ry, offs_y, span_y);
      if (has_prev) begin
         tx = blend(prev_x, tx);
         ty = blend(prev_y, ty);
      end
      prev_x = tx;
      prev_y = ty;
      has_prev = 1;
      pos_queue.push_back({ty, tx});
   endfunction

   task automatic send_word(input logic kind, input logic [11:0] rx, input logic [11:0] ry);
      while (tx_idle_ok && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ry, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_position(kind, rx, ry);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pos_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [13:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         REG_ADC_FULL_SCALE:  full_scale = val[11:0];
         REG_SCREEN_WIDTH:    span_x = val[11:0];
         REG_SCREEN_HEIGHT:   span_y = val[11:0];
         REG_CURVE_EXPONENT:  curve_exp = val[10:0];
         REG_SMOOTH_WEIGHT:   smooth_w = val[7:0];
         REG_DEAD_ZONE_WIDTH: dz_width = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [13:0] fs, sw, sh, ce, wt, dz);
      write_reg(REG_ADC_FULL_SCALE, fs);
      write_reg(REG_SCREEN_WIDTH, sw);
      write_reg(REG_SCREEN_HEIGHT, sh);
      write_reg(REG_CURVE_EXPONENT, ce);
      write_reg(REG_SMOOTH_WEIGHT, wt);
      write_reg(REG_DEAD_ZONE_WIDTH, dz);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed();
      send_word(1'b0, 12'd2048, 12'd2048);
      send_word(1'b0, 12'd0, 12'd4095);
      send_word(1'b0, 12'd4095, 12'd0);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'd4095, 12'd4095);
      drain();
      write_all(14'd4095, 14'd4095, 14'd4095, 14'd1024, 14'd243, 14'd8192);
      send_word(1'b0, 12'd2000, 12'd2100);
      send_word(1'b0, 12'd100, 12'd4000);
      drain();
      write_all(14'd2000, 14'd0, 14'd1, 14'd2047, 14'd255, 14'd300);
      send_word(1'b0, 12'd1000, 12'd3000);
      send_word(1'b0, 12'd1200, 12'd900);
      send_word(1'b0, 12'd4095, 12'd0);
      drain();
      write_all(14'd0, 14'd800, 14'd600, 14'd0, 14'd128, 14'd16383);
      send_word(1'b0, 12'd1234, 12'd225);
      send_word(1'b1, 12'd4095, 12'd4095);
      send_word(1'b0, 12'd77, 12'd88);
      drain();
      write_all(14'd4095, 14'd800, 14'd600, 14'd384, 14'd64, 14'd200);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd2048, 12'd2048);
      send_word(1'b0, 12'd2600, 12'd1300);
      drain();
   endtask

   task automatic random_block(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 4)
            send_word(1'b1, 12'($urandom), 12'($urandom));
         else if ($urandom_range(99) < 60)
            send_word(1'b0, 12'($urandom_range(1500, 2600)), 12'($urandom_range(1500, 2600)));
         else
            send_word(1'b0, 12'($urandom), 12'($urandom));
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         write_all(phase == 3 ? 14'd0 : 14'($urandom_range(1, 4095)),
                   14'($urandom_range(0, 4095)), 14'($urandom_range(0, 4095)),
                   14'($urandom_range(0, 2047)), 14'($urandom_range(0, 255)),
                   14'($urandom_range(0, 9000)));
         send_word(1'b1, 12'd0, 12'd0);
         tx_idle_ok = (phase != 5);
         random_block(phase == 3 ? 40 : 190);
         tx_idle_ok = 1'b1;
         drain();
      end
   endtask

   task automatic test_backpressure();
      write_all(14'd4095, 14'd800, 14'd600, 14'd512, 14'd100, 14'd0);
      hold_cycles = 400;
      random_block(20);
      drain();
   endtask

   // receiver side
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rx_idle_ok || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pos_queue.size() == 0) begin
            report("unexpected word", rsp_tdata, '0);
         end else begin
            if (rsp_tdata[19:0] != pos_queue[0][19:0])
               report("pos_x", rsp_tdata[19:0], pos_queue[0][19:0]);
            if (rsp_tdata[39:20] != pos_queue[0][39:20])
               report("pos_y", rsp_tdata[39:20], pos_queue[0][39:20]);
            void'(pos_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [63:0] r;
      r = 64'd1 << (WQ + 1);
      for (int k = 0; k < 16; k++) begin
         r = int_sqrt(r << WQ);
         roots[k] = r[31:0];
      end
      full_scale = 4095;
      span_x = 800;
      span_y = 600;
      curve_exp = 256;
      smooth_w = 0;
      dz_width = 0;
      predict_position(1'b1, 12'd0, 12'd0);
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random();
      rx_idle_ok = 1'b0;
      random_block(100);
      rx_idle_ok = 1'b1;
      drain();
      test_backpressure();
      if (errors == 0 && pos_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/jac_pkg.sv
sv/joystick_axis_conditioner.sv
sv/jac_checker.sv
tb/tb_top.sv
